### sv/iirdf2_pkg.sv
// ----------------------------------------------------------------------------
// iirdf2_pkg
// Shared widths, register map and multiply-accumulate control codes for the
// direct-form-II IIR filter.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

    // block sizing
    localparam int CHANNELS    = 2;
    localparam int MAX_ORDER   = 3;
    localparam int SAMPLE_BITS = 16;

    // fixed field formats
    localparam int CH_W       = 1;
    localparam int ORDER_W    = 2;
    localparam int COEF_W     = 24;
    localparam int WORD_W     = 40;
    localparam int NUM_FF     = 4;
    localparam int NUM_FB     = 3;
    localparam int COEF_IDX_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;

    // derived widths
    localparam int TAP_W  = $clog2(MAX_ORDER + 1);
    localparam int LINE_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HALF_W = WORD_W / 2;
    localparam int MUL_W  = COEF_W + HALF_W + 1;
    localparam int PROD_W = COEF_W + WORD_W;
    localparam int ACC_W  = 62;

    // fixed-point shifts
    localparam int PROD_SHIFT = 4;
    localparam int X_SHIFT    = 24;
    localparam int W0_SHIFT   = 16;
    localparam int Y_SHIFT    = 24;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FF3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB1   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB2   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FB3   = 3'd7;

    // multiply-accumulate operations
    localparam logic [2:0] MAC_NOP  = 3'd0;
    localparam logic [2:0] MAC_LOAD = 3'd1;
    localparam logic [2:0] MAC_LO   = 3'd2;
    localparam logic [2:0] MAC_HI   = 3'd3;
    localparam logic [2:0] MAC_SUM  = 3'd4;
    localparam logic [2:0] MAC_ACC  = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic       sub;
    } mac_ctrl_t;

endpackage

### sv/iirdf2_mac.sv
// ----------------------------------------------------------------------------
// iirdf2_mac
// Shared multiply-accumulate unit: a coefficient times a delay word is built
// from two half-word products, reduced by the product shift and added to or
// subtracted from the accumulator.
// ----------------------------------------------------------------------------
module iirdf2_mac (
    input  logic                                     aclk,
    input  iirdf2_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [iirdf2_pkg::COEF_W-1:0]     coef,
    input  logic signed [iirdf2_pkg::WORD_W-1:0]     word,
    input  logic signed [iirdf2_pkg::ACC_W-1:0]      acc_init,
    output logic signed [iirdf2_pkg::ACC_W-1:0]      acc
);
    import iirdf2_pkg::*;

    logic signed [HALF_W:0]   mul_b;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [MUL_W-1:0]  lo_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  term;

    // low half is unsigned, high half carries the sign
    assign mul_b = (ctrl.op == MAC_HI) ? $signed({word[WORD_W-1], word[WORD_W-1:HALF_W]})
                                       : $signed({1'b0, word[HALF_W-1:0]});

    // product reduced to the accumulator scale, floor rounding
    assign term = ACC_W'(prod_reg >>> PROD_SHIFT);

    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            MAC_LOAD: begin
                acc_reg <= acc_init;
            end
            MAC_LO: begin
                mul_reg <= coef * mul_b;
            end
            MAC_HI: begin
                lo_reg  <= mul_reg;
                mul_reg <= coef * mul_b;
            end
            MAC_SUM: begin
                prod_reg <= (PROD_W'(mul_reg) <<< HALF_W) + PROD_W'(lo_reg);
            end
            MAC_ACC: begin
                acc_reg <= ctrl.sub ? (acc_reg - term) : (acc_reg + term);
            end
            default: begin
            end
        endcase
    end

    assign acc = acc_reg;

endmodule

### sv/iir_direct_form_two_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form_two_filter
// Per-channel direct-form-II IIR filter of order 0 to 3 on one shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one sample per transaction, tdata = sample, tuser = channel.
//   m_ channel: one filtered sample per input, tuser echoes the channel.
//   cfg channel: register writes (order, numerator and denominator
//   coefficients), always ready; write only while the filter is idle.
// Sequence
//   Each coefficient tap takes four steps on the shared multiplier (two
//   half-word products, a combine and an accumulate). With order N an item
//   runs the N feedback taps, the new delay word, the N+1 feedforward taps,
//   the magnitude step and the rounding step in that order; s_tready stays
//   low until the item is finished, so no new sample is taken meanwhile.
// Reset
//   aresetn (synchronous, active low) clears both delay lines, loads the
//   default coefficients (pass-through) and empties the output register.
// Back-pressure
//   A finished result waits in the output register; the next sample can be
//   taken and processed, and only its final rounding step waits for m_tready.
// ----------------------------------------------------------------------------
module iir_direct_form_two_filter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input samples
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [iirdf2_pkg::TDATA_W-1:0]         s_tdata,   // sample_in
    input  logic [iirdf2_pkg::CH_W-1:0]            s_tuser,   // channel
    // filtered samples
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [iirdf2_pkg::TDATA_W-1:0]         m_tdata,   // sample_out
    output logic [iirdf2_pkg::CH_W-1:0]            m_tuser,   // channel_out
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [iirdf2_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iirdf2_pkg::COEF_W-1:0]          cfg_data
);
    import iirdf2_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LO   = 3'd1;
    localparam logic [2:0] ST_HI   = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_W0   = 3'd5;
    localparam logic [2:0] ST_ABS  = 3'd6;
    localparam logic [2:0] ST_RND  = 3'd7;

    localparam logic signed [ACC_W-1:0] WORD_MAX_A =
        {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] WORD_MIN_A = ~WORD_MAX_A;
    localparam logic [ACC_W-1:0] Y_LIM = ACC_W'((64'd1 << (SAMPLE_BITS-1)) - 64'd1);
    localparam logic [COEF_W-1:0] FF0_RESET = COEF_W'(1048576);

    // configuration registers
    logic [ORDER_W-1:0]       order_reg;
    logic signed [COEF_W-1:0] ff_reg  [NUM_FF];
    logic signed [COEF_W-1:0] fbk_reg [NUM_FB];

    // delay lines
    logic signed [WORD_W-1:0] line_reg [CHANNELS][MAX_ORDER];
    logic signed [WORD_W-1:0] tap_reg  [MAX_ORDER+1];

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [TAP_W-1:0]  k_reg;
    logic [TAP_W-1:0]  ord_reg;
    logic              fb_phase_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [LINE_W-1:0] line_sel_reg;
    logic              neg_reg;
    logic [ACC_W-1:0]  mag_reg;

    // output register
    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic [CH_W-1:0]    m_tuser_reg;

    logic                     in_acc;
    logic                     out_free;
    logic [LINE_W-1:0]        line_sel;
    logic [TAP_W-1:0]         ord_sat;
    mac_ctrl_t                mac_ctrl;
    logic signed [COEF_W-1:0] mac_coef;
    logic signed [WORD_W-1:0] mac_word;
    logic signed [ACC_W-1:0]  mac_init;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  x_ext;
    logic signed [ACC_W-1:0]  w0_rnd;
    logic signed [ACC_W-1:0]  w0_sh;
    logic signed [WORD_W-1:0] w0_sat;
    logic [ACC_W-1:0]         y_rnd;
    logic [SAMPLE_BITS-1:0]   y_mag;
    logic [SAMPLE_BITS-1:0]   y_val;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // out-of-range channel and order saturate
    assign line_sel = (int'(s_tuser) >= CHANNELS) ? LINE_W'(CHANNELS - 1) : LINE_W'(s_tuser);
    assign ord_sat  = (int'(order_reg) > MAX_ORDER) ? TAP_W'(MAX_ORDER) : TAP_W'(order_reg);

    // input sample scaled to the accumulator format
    assign x_ext = ACC_W'($signed(s_tdata[SAMPLE_BITS-1:0])) <<< X_SHIFT;

    // new delay word: round to Q.8 and saturate
    assign w0_rnd = acc + (ACC_W'(1) <<< (W0_SHIFT - 1));
    assign w0_sh  = w0_rnd >>> W0_SHIFT;
    always_comb begin
        priority if (w0_sh > WORD_MAX_A) begin
            w0_sat = WORD_W'(WORD_MAX_A);
        end else if (w0_sh < WORD_MIN_A) begin
            w0_sat = WORD_W'(WORD_MIN_A);
        end else begin
            w0_sat = WORD_W'(w0_sh);
        end
    end

    // output: round magnitude half up, clamp symmetrically, restore sign
    assign y_rnd = (mag_reg + (ACC_W'(1) << (Y_SHIFT - 1))) >> Y_SHIFT;
    assign y_mag = (y_rnd > Y_LIM) ? SAMPLE_BITS'(Y_LIM) : SAMPLE_BITS'(y_rnd);
    assign y_val = neg_reg ? (~y_mag + SAMPLE_BITS'(1)) : y_mag;

    // operand selection for the shared unit
    assign mac_coef = fb_phase_reg ? fbk_reg[COEF_IDX_W'(k_reg) - COEF_IDX_W'(1)]
                                   : ff_reg[COEF_IDX_W'(k_reg)];
    assign mac_word = tap_reg[k_reg];
    assign mac_init = (state_reg == ST_W0) ? '0 : x_ext;

    always_comb begin
        mac_ctrl.sub = fb_phase_reg;
        unique case (state_reg)
            ST_IDLE: mac_ctrl.op = in_acc ? MAC_LOAD : MAC_NOP;
            ST_LO:   mac_ctrl.op = MAC_LO;
            ST_HI:   mac_ctrl.op = MAC_HI;
            ST_SUM:  mac_ctrl.op = MAC_SUM;
            ST_ACC:  mac_ctrl.op = MAC_ACC;
            ST_W0:   mac_ctrl.op = MAC_LOAD;
            default: mac_ctrl.op = MAC_NOP;
        endcase
    end

    iirdf2_mac u_mac (
        .aclk     (aclk),
        .ctrl     (mac_ctrl),
        .coef     (mac_coef),
        .word     (mac_word),
        .acc_init (mac_init),
        .acc      (acc)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (ord_sat == '0) ? ST_W0 : ST_LO;
                end
            end
            ST_LO:  state_next = ST_HI;
            ST_HI:  state_next = ST_SUM;
            ST_SUM: state_next = ST_ACC;
            ST_ACC: begin
                if (k_reg == ord_reg) begin
                    state_next = fb_phase_reg ? ST_W0 : ST_ABS;
                end else begin
                    state_next = ST_LO;
                end
            end
            ST_W0:  state_next = ST_LO;
            ST_ABS: state_next = ST_RND;
            ST_RND: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RND && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= '0;
            ff_reg[0] <= FF0_RESET;
            for (int i = 1; i < NUM_FF; i++) begin
                ff_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_FB; i++) begin
                fbk_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ORDER: order_reg  <= cfg_data[ORDER_W-1:0];
                REG_FF0:   ff_reg[0]  <= cfg_data;
                REG_FF1:   ff_reg[1]  <= cfg_data;
                REG_FF2:   ff_reg[2]  <= cfg_data;
                REG_FF3:   ff_reg[3]  <= cfg_data;
                REG_FB1:   fbk_reg[0] <= cfg_data;
                REG_FB2:   fbk_reg[1] <= cfg_data;
                REG_FB3:   fbk_reg[2] <= cfg_data;
            endcase
        end
    end

    // delay lines: cleared at reset, shifted once the new word is known
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int j = 0; j < MAX_ORDER; j++) begin
                    line_reg[c][j] <= '0;
                end
            end
        end else if (state_reg == ST_W0) begin
            line_reg[line_sel_reg][0] <= w0_sat;
            for (int j = 1; j < MAX_ORDER; j++) begin
                line_reg[line_sel_reg][j] <= tap_reg[j];
            end
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    ch_reg       <= s_tuser;
                    line_sel_reg <= line_sel;
                    ord_reg      <= ord_sat;
                    k_reg        <= TAP_W'(1);
                    fb_phase_reg <= 1'b1;
                    for (int j = 1; j <= MAX_ORDER; j++) begin
                        tap_reg[j] <= line_reg[line_sel][j-1];
                    end
                end
            end
            ST_ACC: begin
                if (k_reg != ord_reg) begin
                    k_reg <= k_reg + TAP_W'(1);
                end
            end
            ST_W0: begin
                tap_reg[0]   <= w0_sat;
                k_reg        <= '0;
                fb_phase_reg <= 1'b0;
            end
            ST_ABS: begin
                neg_reg <= acc[ACC_W-1];
                mag_reg <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
            end
            ST_RND: begin
                if (out_free) begin
                    m_tdata_reg <= TDATA_W'(y_val);
                    m_tuser_reg <= ch_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // an accepted sample keeps the input closed for the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready directly after an accepted transaction");

    // tap counter stays within the order, feedback never uses tap zero
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LO || state_reg == ST_HI || state_reg == ST_SUM ||
         state_reg == ST_ACC) |-> ((k_reg <= ord_reg) && !(fb_phase_reg && k_reg == '0)))
        else $error("tap counter out of range");

    // a new result only comes out of the rounding step
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_RND))
        else $error("output valid raised outside the rounding step");
`endif

endmodule
